// ===== design/pph_pkg.sv =====
// ----------------------------------------------------------------------------
// pph_pkg
// Shared types and constants of the particle projection histogram.
// ----------------------------------------------------------------------------
package pph_pkg;

  // Map geometry: square grid, bin and cell indexes of BW bits
  localparam int GRID_SIZE = 512;
  localparam int BW        = $clog2(GRID_SIZE);

  localparam logic [1:0] OP_DEPOSIT = 2'd0;
  localparam logic [1:0] OP_READ    = 2'd1;
  localparam logic [1:0] OP_CLEAR   = 2'd2;

  localparam logic [2:0] REG_LOW_X     = 3'd0;
  localparam logic [2:0] REG_LOW_Y     = 3'd1;
  localparam logic [2:0] REG_LOW_Z     = 3'd2;
  localparam logic [2:0] REG_BIN_SCALE = 3'd3;
  localparam logic [2:0] REG_CENTER_X  = 3'd4;
  localparam logic [2:0] REG_CENTER_Y  = 3'd5;
  localparam logic [2:0] REG_CENTER_Z  = 3'd6;
  localparam logic [2:0] REG_RADIUS_SQ = 3'd7;

  localparam logic [23:0] CNT_MAX  = 24'hFFFFFF;
  localparam logic [31:0] KEPT_MAX = 32'hFFFFFFFF;
  localparam logic [47:0] MASS_MAX = 48'hFFFFFFFFFFFF;

  // Back-end sequencer states
  typedef enum logic [2:0] {
    ST_CLEARING,
    ST_IDLE,
    ST_READ,
    ST_WRITE,
    ST_DONE
  } be_state_t;

endpackage

// ===== design/pph_front.sv =====
// ----------------------------------------------------------------------------
// pph_front
// Classifies items: radius cut and axis binning over a short pipeline.
// One item at a time; an item reaches the back after the subtract, multiply and classify steps.
// ----------------------------------------------------------------------------
module pph_front
  import pph_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        operation,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic [31:0]       mass,
  input  logic [8:0]        cell_row,
  input  logic [8:0]        cell_col,
  input  logic signed [31:0] low_x,
  input  logic signed [31:0] low_y,
  input  logic signed [31:0] low_z,
  input  logic [31:0]       bin_scale,
  input  logic signed [31:0] center_x,
  input  logic signed [31:0] center_y,
  input  logic signed [31:0] center_z,
  input  logic [62:0]       radius_sq,
  output logic              q_valid,
  input  logic              q_ready,
  output logic [1:0]        q_op,
  output logic              q_keep,
  output logic [BW-1:0]     q_bx,
  output logic [BW-1:0]     q_by,
  output logic [BW-1:0]     q_bz,
  output logic [31:0]       q_mass,
  output logic              q_cell_ok,
  output logic [8:0]        q_row,
  output logic [8:0]        q_col
);

  logic [2:0] stage;
  logic [1:0] op;
  logic signed [32:0] px, py, pz, dlx, dly, dlz, dcx, dcy, dcz;
  logic [31:0] ms;
  logic [8:0] row, col;
  logic [32:0] ax, ay, az;
  logic [65:0] sx, sy, sz;
  logic [64:0] prx, pry, prz;
  logic [65:0] d2;
  logic keep;

  assign in_ready = (stage == 3'd0);

  // Absolute differences of the center offsets and their summed squares
  always_comb begin
    ax = dcx[32] ? 33'(-dcx) : 33'(dcx);
    ay = dcy[32] ? 33'(-dcy) : 33'(dcy);
    az = dcz[32] ? 33'(-dcz) : 33'(dcz);
    d2 = sx + sy + sz;
  end

  function automatic logic [BW-1:0] clamp_bin(input logic signed [32:0] d,
                                              input logic [64:0] p);
    logic [32:0] q;
    q = p[64:32];
    if (d[32]) return '0;
    if (q >= 33'(GRID_SIZE)) return BW'(GRID_SIZE - 1);
    return q[BW-1:0];
  endfunction

  // Advance the item through subtract, multiply and classify steps
  always_ff @(posedge clk) begin
    if (rst) begin
      stage <= 3'd0;
    end else begin
      case (stage)
        3'd0: if (in_valid) begin
          op <= operation; ms <= mass; row <= cell_row; col <= cell_col;
          px <= 33'(pos_x); py <= 33'(pos_y); pz <= 33'(pos_z);
          dlx <= 33'(pos_x) - 33'(low_x);
          dly <= 33'(pos_y) - 33'(low_y);
          dlz <= 33'(pos_z) - 33'(low_z);
          dcx <= 33'(pos_x) - 33'(center_x);
          dcy <= 33'(pos_y) - 33'(center_y);
          dcz <= 33'(pos_z) - 33'(center_z);
          stage <= 3'd1;
        end
        3'd1: begin
          sx <= 66'(ax[31:0] * ax[31:0]);
          sy <= 66'(ay[31:0] * ay[31:0]);
          sz <= 66'(az[31:0] * az[31:0]);
          prx <= 65'(dlx[31:0] * bin_scale);
          pry <= 65'(dly[31:0] * bin_scale);
          prz <= 65'(dlz[31:0] * bin_scale);
          stage <= 3'd2;
        end
        3'd2: begin
          keep <= (radius_sq == '0) ||
                  ((d2[65:64] == 2'b00) && (d2[63:0] < 64'(radius_sq)));
          q_bx <= clamp_bin(dlx, prx);
          q_by <= clamp_bin(dly, pry);
          q_bz <= clamp_bin(dlz, prz);
          stage <= 3'd3;
        end
        3'd3: if (q_ready) stage <= 3'd0;
        default: stage <= 3'd0;
      endcase
    end
  end

  assign q_valid   = (stage == 3'd3);
  assign q_op      = op;
  assign q_keep    = keep;
  assign q_mass    = ms;
  assign q_cell_ok = (32'(row) < 32'(GRID_SIZE)) && (32'(col) < 32'(GRID_SIZE));
  assign q_row     = row;
  assign q_col     = col;

endmodule

// ===== design/pph_back.sv =====
// ----------------------------------------------------------------------------
// pph_back
// Carries out classified items: map read-modify-write, totals, results.
// ----------------------------------------------------------------------------
module pph_back
  import pph_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  output logic          q_ready,
  input  logic [1:0]    q_op,
  input  logic          q_keep,
  input  logic [BW-1:0] q_bx,
  input  logic [BW-1:0] q_by,
  input  logic [BW-1:0] q_bz,
  input  logic [31:0]   q_mass,
  input  logic          q_cell_ok,
  input  logic [8:0]    q_row,
  input  logic [8:0]    q_col,
  output logic          empty,
  input  logic          pop,
  output logic          accepted,
  output logic [8:0]    bin_x,
  output logic [8:0]    bin_y,
  output logic [8:0]    bin_z,
  output logic [23:0]   count_xy,
  output logic [23:0]   count_xz,
  output logic [23:0]   count_yz,
  output logic [31:0]   kept_total,
  output logic [47:0]   mass_total
);

  localparam int AW = 2 * BW;
  localparam int CELLS = GRID_SIZE * GRID_SIZE;

  logic [23:0] mem_xy [CELLS];
  logic [23:0] mem_xz [CELLS];
  logic [23:0] mem_yz [CELLS];

  be_state_t state, state_next;
  logic [AW:0] clr_cnt;
  logic [AW-1:0] a_xy, a_xz, a_yz;
  logic [23:0] r_xy, r_xz, r_yz;
  logic [31:0] kept;
  logic [47:0] msum;
  logic [48:0] msum_add;
  logic dep, rd, we;
  logic [23:0] w_xy, w_xz, w_yz;

  assign dep = (q_op == OP_DEPOSIT) && q_keep;
  assign rd  = (q_op == OP_READ) && q_cell_ok;

  // Addresses per map
  always_comb begin
    if (q_op == OP_READ) begin
      a_xy = AW'({q_row[BW-1:0], q_col[BW-1:0]});
      a_xz = a_xy;
      a_yz = a_xy;
    end else begin
      a_xy = {q_bx, q_by};
      a_xz = {q_bx, q_bz};
      a_yz = {q_by, q_bz};
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEARING: if (clr_cnt == (AW+1)'(CELLS - 1)) state_next = ST_IDLE;
      ST_IDLE:     if (q_valid) state_next = (dep || rd) ? ST_READ : ST_WRITE;
      ST_READ:     state_next = ST_WRITE;
      ST_WRITE:    state_next = ST_DONE;
      ST_DONE:     if (pop) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    we      = 1'b0;
    q_ready = 1'b0;
    w_xy = '0; w_xz = '0; w_yz = '0;
    case (state)
      ST_CLEARING: we = 1'b1;
      ST_WRITE: begin
        q_ready = 1'b1;
        we = dep || rd;
        if (dep) begin
          w_xy = (r_xy == CNT_MAX) ? r_xy : r_xy + 24'd1;
          w_xz = (r_xz == CNT_MAX) ? r_xz : r_xz + 24'd1;
          w_yz = (r_yz == CNT_MAX) ? r_yz : r_yz + 24'd1;
        end
      end
      default: ;
    endcase
  end

  assign empty = (state != ST_DONE);
  assign msum_add = 49'(msum) + 49'(q_mass);

  // Memory ports: registered read, one write
  always_ff @(posedge clk) begin
    if (state == ST_CLEARING) begin
      mem_xy[clr_cnt[AW-1:0]] <= '0;
      mem_xz[clr_cnt[AW-1:0]] <= '0;
      mem_yz[clr_cnt[AW-1:0]] <= '0;
    end else if (we) begin
      mem_xy[a_xy] <= w_xy;
      mem_xz[a_xz] <= w_xz;
      mem_yz[a_yz] <= w_yz;
    end
    r_xy <= mem_xy[a_xy];
    r_xz <= mem_xz[a_xz];
    r_yz <= mem_yz[a_yz];
  end

  // Sequencer, totals and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEARING;
      clr_cnt <= '0;
      kept    <= '0;
      msum    <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEARING) clr_cnt <= clr_cnt + 1'b1;
      if (state == ST_WRITE) begin
        accepted <= dep;
        bin_x <= dep ? 9'(q_bx) : '0;
        bin_y <= dep ? 9'(q_by) : '0;
        bin_z <= dep ? 9'(q_bz) : '0;
        count_xy <= rd ? r_xy : '0;
        count_xz <= rd ? r_xz : '0;
        count_yz <= rd ? r_yz : '0;
        if (q_op == OP_CLEAR) begin
          kept <= '0; msum <= '0;
          kept_total <= '0; mass_total <= '0;
        end else if (dep) begin
          kept <= (kept == KEPT_MAX) ? kept : kept + 32'd1;
          kept_total <= (kept == KEPT_MAX) ? kept : kept + 32'd1;
          msum <= (msum_add > 49'(MASS_MAX)) ? MASS_MAX : msum_add[47:0];
          mass_total <= (msum_add > 49'(MASS_MAX)) ? MASS_MAX : msum_add[47:0];
        end else begin
          kept_total <= kept; mass_total <= msum;
        end
      end
    end
  end

endmodule

// ===== design/particle_projection_histogram_top.sv =====
// ----------------------------------------------------------------------------
// particle_projection_histogram_top
// Bins 3-D particles into xy, xz and yz count maps with totals.
// ----------------------------------------------------------------------------
//  channel  | handshake        | payload
//  input    | push / full      | operation, pos_x..z, mass, cell_row, cell_col
//  result   | empty / pop      | accepted, bin_x..z, count_*, kept_total, mass_total
//  config   | cfg_we           | cfg_index, cfg_data
//
// The front subtracts, multiplies and classifies, then hands an item to the
// back. The back reads the maps, then writes them and registers the result;
// items other than kept deposits and cell reads skip the map read. The front
// takes a new item once the back has taken the last. After reset the back
// clears GRID_SIZE*GRID_SIZE map entries, one per cycle, before taking items.
// A waiting result stalls the back; the front takes one more item and full
// stays high until the back takes it.
module particle_projection_histogram_top
  import pph_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [1:0]        operation,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic [31:0]       mass,
  input  logic [8:0]        cell_row,
  input  logic [8:0]        cell_col,
  output logic              empty,
  input  logic              pop,
  output logic              accepted,
  output logic [8:0]        bin_x,
  output logic [8:0]        bin_y,
  output logic [8:0]        bin_z,
  output logic [23:0]       count_xy,
  output logic [23:0]       count_xz,
  output logic [23:0]       count_yz,
  output logic [31:0]       kept_total,
  output logic [47:0]       mass_total,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [62:0]       cfg_data
);

  logic signed [31:0] low_x, low_y, low_z, center_x, center_y, center_z;
  logic [31:0] bin_scale;
  logic [62:0] radius_sq;
  logic in_ready, q_valid, q_ready, q_keep, q_cell_ok;
  logic [1:0] q_op;
  logic [BW-1:0] q_bx, q_by, q_bz;
  logic [31:0] q_mass;
  logic [8:0] q_row, q_col;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      low_x <= '0; low_y <= '0; low_z <= '0;
      center_x <= '0; center_y <= '0; center_z <= '0;
      bin_scale <= 32'd16777216;
      radius_sq <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LOW_X:     low_x <= cfg_data[31:0];
        REG_LOW_Y:     low_y <= cfg_data[31:0];
        REG_LOW_Z:     low_z <= cfg_data[31:0];
        REG_BIN_SCALE: bin_scale <= cfg_data[31:0];
        REG_CENTER_X:  center_x <= cfg_data[31:0];
        REG_CENTER_Y:  center_y <= cfg_data[31:0];
        REG_CENTER_Z:  center_z <= cfg_data[31:0];
        REG_RADIUS_SQ: radius_sq <= cfg_data;
        default: ;
      endcase
    end
  end

  assign full = !in_ready;

  pph_front u_front (
    .clk, .rst, .in_valid(push), .in_ready,
    .operation, .pos_x, .pos_y, .pos_z, .mass, .cell_row, .cell_col,
    .low_x, .low_y, .low_z, .bin_scale, .center_x, .center_y, .center_z,
    .radius_sq, .q_valid, .q_ready, .q_op, .q_keep, .q_bx, .q_by, .q_bz,
    .q_mass, .q_cell_ok, .q_row, .q_col
  );

  pph_back u_back (
    .clk, .rst, .q_valid, .q_ready, .q_op, .q_keep, .q_bx, .q_by, .q_bz,
    .q_mass, .q_cell_ok, .q_row, .q_col, .empty, .pop, .accepted,
    .bin_x, .bin_y, .bin_z, .count_xy, .count_xz, .count_yz,
    .kept_total, .mass_total
  );

  // A result carries bins only for an accepted deposit
  a_bins_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && !accepted) |-> (bin_x == '0 && bin_y == '0 && bin_z == '0))
    else $error("bins set on a non-deposit result");

  // A deposit result never carries counts
  a_counts_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && accepted) |-> (count_xy == '0 && count_xz == '0 && count_yz == '0))
    else $error("counts set on a deposit result");

  // A waiting result holds until popped
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(kept_total) && $stable(mass_total)))
    else $error("result changed while waiting");

endmodule
